>>> sv/sdac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdac_pkg
// Shared constants, codes and divider handshake types of the staged door
// actuator controller.
// ----------------------------------------------------------------------------
package sdac_pkg;

  localparam int NUM_DOORS  = 5;
  localparam int NUM_STAGES = 5;
  localparam int TICK_MS    = 100;
  localparam int OS_TICK_MS = 1;

  localparam int POS_W   = 10;
  localparam int TRAV_W  = 16;
  localparam int TS_W    = 32;
  localparam int DIV_NW  = 32;
  localparam int DIV_DW  = 20;
  localparam int DIV_CW  = $clog2(DIV_NW);

  localparam logic [POS_W-1:0] POS_FULL  = POS_W'(1000);
  localparam logic [POS_W-1:0] OPEN_LIM  = POS_W'(990);
  localparam logic [POS_W-1:0] CLOSE_LIM = POS_W'(10);
  localparam logic [POS_W-1:0] DEADBAND  = POS_W'(5);
  localparam logic [DIV_NW-1:0] STEP_NUM = DIV_NW'(1000 * TICK_MS);

  typedef enum logic [2:0] {
    FN_TICK      = 3'd0,
    FN_START_CAL = 3'd1,
    FN_SET_OPEN  = 3'd2,
    FN_SET_CLOSE = 3'd3,
    FN_SAFE      = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    CFG_OPEN_FRACTION = 2'd0,
    CFG_DEFAULT_TRAVEL = 2'd1,
    CFG_STAGE_MAP      = 2'd2
  } cfg_idx_t;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_OPENING = 2'd1;
  localparam logic [1:0] PH_CLOSING = 2'd2;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quo;
  } div_rsp_t;

endpackage

>>> sv/sdac_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdac_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sdac_div
  import sdac_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_DW:0]   rem_r, rem_nxt;
  logic [DIV_NW-1:0] quo_r, quo_nxt;
  logic [DIV_DW-1:0] den_r, den_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_DW:0]   rem_sh;
  logic              fits;

  assign rem_sh = {rem_r[DIV_DW-1:0], quo_r[DIV_NW-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.num;
      den_nxt  = req.den;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? rem_sh - {1'b0, den_r} : rem_sh;
      quo_nxt = {quo_r[DIV_NW-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CW'(DIV_NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

>>> sv/staged_door_actuator_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// staged_door_actuator_controller_unit
// Staged target split, per-door stepping and calibration for five doors.
// ----------------------------------------------------------------------------
// a run tick makes up to 11 serial divisions, a calibration tick at most one
// one item at a time; all divisions go through the shared bit-serial divider
// the next item is taken while a finished result waits on the output
// synchronous active-low reset: doors closed, travel times cleared, idle
module staged_door_actuator_controller_unit
  import sdac_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [2:0]  in_door,
  input  logic [15:0] in_value,
  input  logic [31:0] in_now_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_open_drive,
  output logic [4:0]  out_close_drive,
  output logic [4:0]  out_open_limits,
  output logic [4:0]  out_close_limits,
  output logic [4:0]  out_moving_mask,
  output logic [4:0]  out_calibrated_mask,
  output logic        out_calibrating,
  output logic [1:0]  out_cal_phase,
  output logic [2:0]  out_active_stage_count,
  output logic [9:0]  out_selected_position,
  output logic [9:0]  out_selected_target,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b000000000001,
    ST_EXEC   = 12'b000000000010,
    ST_SUM    = 12'b000000000100,
    ST_BDIV   = 12'b000000001000,
    ST_STAGE  = 12'b000000010000,
    ST_TDIV   = 12'b000000100000,
    ST_RSTEP  = 12'b000001000000,
    ST_RAPPLY = 12'b000010000000,
    ST_CSTEP  = 12'b000100000000,
    ST_CDOOR  = 12'b001000000000,
    ST_CFIN   = 12'b010000000000,
    ST_FIN    = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [9:0]  frac_r;
  logic [15:0] dflt_r;
  logic [14:0] smap_r;

  logic [POS_W-1:0]  pos_r [NUM_DOORS];
  logic [POS_W-1:0]  pos_nxt [NUM_DOORS];
  logic [POS_W-1:0]  tgt_r [NUM_DOORS];
  logic [POS_W-1:0]  tgt_nxt [NUM_DOORS];
  logic [TRAV_W-1:0] otr_r [NUM_DOORS];
  logic [TRAV_W-1:0] otr_nxt [NUM_DOORS];
  logic [TRAV_W-1:0] ctr_r [NUM_DOORS];
  logic [TRAV_W-1:0] ctr_nxt [NUM_DOORS];
  logic [TS_W-1:0]   cs_r [NUM_DOORS];
  logic [TS_W-1:0]   cs_nxt [NUM_DOORS];
  logic [4:0] mov_r, mov_nxt, opn_r, opn_nxt, cls_r, cls_nxt, cal_r, cal_nxt;
  logic [4:0] od_r, od_nxt, cd_r, cd_nxt;
  logic       calib_r, calib_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [2:0] scnt_r, scnt_nxt;

  logic [2:0]  func_r, func_nxt, door_r, door_nxt;
  logic [15:0] val_r, val_nxt;
  logic [31:0] now_r, now_nxt;
  logic [2:0]  i_r, i_nxt, st_r, st_nxt;
  logic [18:0] total_r, total_nxt, budget_r, budget_nxt;
  logic [15:0] used_r, used_nxt;
  logic [POS_W-1:0] step_r, step_nxt;
  logic        pend_r, pend_nxt;
  logic        ov_r, ov_nxt;

  logic [4:0] o_od_r, o_cd_r, o_ol_r, o_cl_r, o_mv_r, o_cb_r;
  logic       o_cal_r;
  logic [1:0] o_ph_r;
  logic [2:0] o_sc_r;
  logic [9:0] o_pos_r, o_tgt_r;
  logic       o_load;

  div_req_t dreq;
  div_rsp_t drsp;

  sdac_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .rsp  (drsp)
  );

  // per-door parallel views
  logic [2:0]        stg [NUM_DOORS];
  logic [TRAV_W-1:0] eo  [NUM_DOORS];
  logic [TRAV_W-1:0] ec  [NUM_DOORS];
  logic [18:0]       total_c;
  logic [TRAV_W-1:0] maxt_c;
  logic [4:0]        active_c;

  always_comb begin
    total_c  = '0;
    maxt_c   = '0;
    active_c = '0;
    for (int k = 0; k < NUM_DOORS; k++) begin
      stg[k] = smap_r[3*k +: 3];
      eo[k]  = (cal_r[k] && otr_r[k] != '0) ? otr_r[k] : dflt_r;
      ec[k]  = (cal_r[k] && ctr_r[k] != '0) ? ctr_r[k] : dflt_r;
      if (stg[k] != 3'd0) total_c = total_c + 19'(eo[k]);
      if (stg[k] == st_r && eo[k] > maxt_c) maxt_c = eo[k];
      if (tgt_r[k] != '0 && stg[k] >= 3'd1 && stg[k] <= 3'(NUM_STAGES))
        active_c[stg[k] - 3'd1] = 1'b1;
    end
  end

  // single read port into the per-door stores
  logic       door_ok;
  logic [2:0] rd_idx;
  logic [POS_W-1:0]  rd_pos, rd_tgt;
  logic [TRAV_W-1:0] rd_eo, rd_ec;
  logic [TS_W-1:0]   rd_cs;

  assign door_ok = door_r < 3'(NUM_DOORS);
  assign rd_idx  = (state_r == ST_FIN) ? (door_ok ? door_r : 3'd0) : i_r;
  assign rd_pos  = pos_r[rd_idx];
  assign rd_tgt  = tgt_r[rd_idx];
  assign rd_eo   = eo[rd_idx];
  assign rd_ec   = ec[rd_idx];
  assign rd_cs   = cs_r[rd_idx];

  logic [TRAV_W-1:0] run_trav;
  logic [POS_W-1:0]  q_step, q_tgt;
  logic [TS_W-1:0]   el_d;
  logic [TS_W+7:0]   el_e;
  logic [TRAV_W-1:0] el;
  logic [POS_W:0]    psum, tsum_hi, tsum_lo, stsum;

  assign run_trav = (rd_pos < rd_tgt) ? rd_eo : rd_ec;
  assign q_step   = (drsp.quo == '0) ? POS_W'(1) :
                    (drsp.quo > DIV_NW'(POS_FULL)) ? POS_FULL : drsp.quo[POS_W-1:0];
  assign q_tgt    = (drsp.quo > DIV_NW'(POS_FULL)) ? POS_FULL : drsp.quo[POS_W-1:0];
  assign el_d     = now_r - rd_cs;
  assign el_e     = (TS_W+8)'(el_d) * (TS_W+8)'(OS_TICK_MS);
  assign el       = (el_e > (TS_W+8)'(16'hFFFF)) ? 16'hFFFF : el_e[15:0];
  assign psum     = {1'b0, rd_pos} + {1'b0, step_r};
  assign tsum_hi  = {1'b0, rd_pos} + {1'b0, DEADBAND};
  assign tsum_lo  = {1'b0, rd_tgt} + {1'b0, DEADBAND};
  assign stsum    = {1'b0, step_r} + {1'b0, rd_tgt};

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    tgt_nxt    = tgt_r;
    otr_nxt    = otr_r;
    ctr_nxt    = ctr_r;
    cs_nxt     = cs_r;
    mov_nxt    = mov_r;
    opn_nxt    = opn_r;
    cls_nxt    = cls_r;
    cal_nxt    = cal_r;
    od_nxt     = od_r;
    cd_nxt     = cd_r;
    calib_nxt  = calib_r;
    phase_nxt  = phase_r;
    scnt_nxt   = scnt_r;
    func_nxt   = func_r;
    door_nxt   = door_r;
    val_nxt    = val_r;
    now_nxt    = now_r;
    i_nxt      = i_r;
    st_nxt     = st_r;
    total_nxt  = total_r;
    budget_nxt = budget_r;
    used_nxt   = used_r;
    step_nxt   = step_r;
    pend_nxt   = pend_r;
    dreq       = '0;
    o_load     = 1'b0;
    ov_nxt     = ov_r && !out_ready;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_func;
          door_nxt  = in_door;
          val_nxt   = in_value;
          now_nxt   = in_now_ticks;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_FIN;
        case (func_r)
          FN_TICK: begin
            if (calib_r) begin
              state_nxt = ST_CSTEP;
            end else begin
              for (int k = 0; k < NUM_DOORS; k++) tgt_nxt[k] = '0;
              state_nxt = ST_SUM;
            end
          end
          FN_START_CAL: begin
            if (!calib_r) begin
              calib_nxt = 1'b1;
              if (&cls_r) begin
                phase_nxt = PH_OPENING;
                for (int k = 0; k < NUM_DOORS; k++) cs_nxt[k] = now_r;
              end else begin
                phase_nxt = PH_CLOSING;
                for (int k = 0; k < NUM_DOORS; k++) begin
                  tgt_nxt[k] = '0;
                  cs_nxt[k]  = cls_r[k] ? '0 : now_r;
                end
              end
            end
          end
          FN_SET_OPEN, FN_SET_CLOSE: begin
            if (door_ok) begin
              if (func_r == FN_SET_OPEN) otr_nxt[door_r] = val_r;
              else ctr_nxt[door_r] = val_r;
              if (val_r != '0 &&
                  ((func_r == FN_SET_OPEN) ? ctr_r[door_r] : otr_r[door_r]) != '0)
                cal_nxt[door_r] = 1'b1;
              if (val_r == '0) cal_nxt[door_r] = 1'b0;
            end
          end
          FN_SAFE: begin
            calib_nxt = 1'b0;
            phase_nxt = PH_IDLE;
            mov_nxt   = '0;
            od_nxt    = '0;
            cd_nxt    = '0;
            for (int k = 0; k < NUM_DOORS; k++) begin
              tgt_nxt[k] = pos_r[k];
              cs_nxt[k]  = '0;
            end
          end
          default: ;
        endcase
      end
      ST_SUM: begin
        i_nxt = '0;
        if (frac_r == '0 || total_c == '0) begin
          state_nxt = ST_RSTEP;
        end else begin
          total_nxt = total_c;
          state_nxt = ST_BDIV;
        end
      end
      ST_BDIV: begin
        dreq.num = DIV_NW'(frac_r) * DIV_NW'(total_r);
        dreq.den = DIV_DW'(POS_FULL);
        if (!pend_r) begin
          dreq.start = 1'b1;
          pend_nxt   = 1'b1;
        end else if (drsp.done) begin
          pend_nxt   = 1'b0;
          budget_nxt = drsp.quo[18:0];
          st_nxt     = 3'd1;
          state_nxt  = ST_STAGE;
        end
      end
      ST_STAGE: begin
        i_nxt = '0;
        if (st_r > 3'(NUM_STAGES) || budget_r == '0) begin
          state_nxt = ST_RSTEP;
        end else if (maxt_c == '0) begin
          st_nxt = st_r + 3'd1;
        end else begin
          used_nxt  = (budget_r < 19'(maxt_c)) ? budget_r[15:0] : maxt_c;
          state_nxt = ST_TDIV;
        end
      end
      ST_TDIV: begin
        dreq.num = DIV_NW'(used_r) * DIV_NW'(POS_FULL);
        dreq.den = DIV_DW'(rd_eo);
        if (i_r == 3'(NUM_DOORS)) begin
          budget_nxt = budget_r - 19'(used_r);
          st_nxt     = st_r + 3'd1;
          state_nxt  = ST_STAGE;
        end else if (stg[i_r] != st_r || rd_eo == '0) begin
          i_nxt = i_r + 3'd1;
        end else if (!pend_r) begin
          dreq.start = 1'b1;
          pend_nxt   = 1'b1;
        end else if (drsp.done) begin
          pend_nxt      = 1'b0;
          tgt_nxt[i_r]  = q_tgt;
          i_nxt         = i_r + 3'd1;
        end
      end
      ST_RSTEP: begin
        dreq.num = STEP_NUM;
        dreq.den = DIV_DW'(run_trav);
        if (i_r == 3'(NUM_DOORS)) begin
          scnt_nxt  = 3'($countones(active_c));
          state_nxt = ST_FIN;
        end else if (run_trav == '0) begin
          step_nxt  = '0;
          state_nxt = ST_RAPPLY;
        end else if (!pend_r) begin
          dreq.start = 1'b1;
          pend_nxt   = 1'b1;
        end else if (drsp.done) begin
          pend_nxt  = 1'b0;
          step_nxt  = q_step;
          state_nxt = ST_RAPPLY;
        end
      end
      ST_RAPPLY: begin
        opn_nxt[i_r] = rd_pos >= OPEN_LIM;
        cls_nxt[i_r] = rd_pos <= CLOSE_LIM;
        mov_nxt[i_r] = 1'b0;
        od_nxt[i_r]  = 1'b0;
        cd_nxt[i_r]  = 1'b0;
        if (step_r == '0) begin
          // frozen door
        end else if ({1'b0, rd_tgt} > tsum_hi && !(rd_pos >= OPEN_LIM)) begin
          mov_nxt[i_r] = 1'b1;
          od_nxt[i_r]  = 1'b1;
          pos_nxt[i_r] = (psum > {1'b0, rd_tgt}) ? rd_tgt : psum[POS_W-1:0];
        end else if (tsum_lo < {1'b0, rd_pos} && !(rd_pos <= CLOSE_LIM)) begin
          mov_nxt[i_r] = 1'b1;
          cd_nxt[i_r]  = 1'b1;
          pos_nxt[i_r] = ({1'b0, rd_pos} < stsum) ? rd_tgt : rd_pos - step_r;
        end else begin
          if (rd_pos >= OPEN_LIM) pos_nxt[i_r] = POS_FULL;
          if (rd_pos <= CLOSE_LIM) pos_nxt[i_r] = '0;
        end
        i_nxt     = i_r + 3'd1;
        state_nxt = ST_RSTEP;
      end
      ST_CSTEP: begin
        dreq.num = STEP_NUM;
        dreq.den = DIV_DW'(dflt_r);
        i_nxt    = '0;
        if (dflt_r == '0) begin
          step_nxt  = '0;
          state_nxt = ST_CDOOR;
        end else if (!pend_r) begin
          dreq.start = 1'b1;
          pend_nxt   = 1'b1;
        end else if (drsp.done) begin
          pend_nxt  = 1'b0;
          step_nxt  = q_step;
          state_nxt = ST_CDOOR;
        end
      end
      ST_CDOOR: begin
        if (i_r == 3'(NUM_DOORS)) begin
          state_nxt = ST_CFIN;
        end else begin
          if (phase_r == PH_OPENING) begin
            mov_nxt[i_r] = 1'b0;
            od_nxt[i_r]  = 1'b0;
            cd_nxt[i_r]  = 1'b0;
            if (!opn_r[i_r]) begin
              mov_nxt[i_r] = 1'b1;
              od_nxt[i_r]  = 1'b1;
              pos_nxt[i_r] = (psum >= {1'b0, POS_FULL}) ? POS_FULL : psum[POS_W-1:0];
              if (psum >= {1'b0, OPEN_LIM}) begin
                opn_nxt[i_r] = 1'b1;
                cls_nxt[i_r] = 1'b0;
                mov_nxt[i_r] = 1'b0;
                od_nxt[i_r]  = 1'b0;
                if (rd_cs != '0) otr_nxt[i_r] = el;
              end
            end
          end else if (phase_r == PH_CLOSING) begin
            mov_nxt[i_r] = 1'b0;
            od_nxt[i_r]  = 1'b0;
            cd_nxt[i_r]  = 1'b0;
            if (!cls_r[i_r]) begin
              mov_nxt[i_r] = 1'b1;
              cd_nxt[i_r]  = 1'b1;
              pos_nxt[i_r] = (rd_pos < step_r) ? '0 : rd_pos - step_r;
              if (rd_pos < step_r || (rd_pos - step_r) <= CLOSE_LIM) begin
                cls_nxt[i_r] = 1'b1;
                opn_nxt[i_r] = 1'b0;
                mov_nxt[i_r] = 1'b0;
                cd_nxt[i_r]  = 1'b0;
                if (rd_cs != '0) ctr_nxt[i_r] = el;
              end
            end
          end
          i_nxt = i_r + 3'd1;
        end
      end
      ST_CFIN: begin
        state_nxt = ST_FIN;
        if ((phase_r == PH_OPENING) ? (&opn_r) : (&cls_r)) begin
          if (phase_r == PH_OPENING) begin
            phase_nxt = PH_CLOSING;
            for (int k = 0; k < NUM_DOORS; k++) cs_nxt[k] = now_r;
          end else begin
            calib_nxt = 1'b0;
            phase_nxt = PH_IDLE;
            cal_nxt   = '1;
            for (int k = 0; k < NUM_DOORS; k++) cs_nxt[k] = '0;
          end
        end
      end
      ST_FIN: begin
        // result register frees up or is empty
        if (!ov_r || out_ready) begin
          o_load    = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    door_r   <= door_nxt;
    val_r    <= val_nxt;
    now_r    <= now_nxt;
    i_r      <= i_nxt;
    st_r     <= st_nxt;
    total_r  <= total_nxt;
    budget_r <= budget_nxt;
    used_r   <= used_nxt;
    step_r   <= step_nxt;
    if (o_load) begin
      o_od_r  <= od_r;
      o_cd_r  <= cd_r;
      o_ol_r  <= opn_r;
      o_cl_r  <= cls_r;
      o_mv_r  <= mov_r;
      o_cb_r  <= cal_r;
      o_cal_r <= calib_r;
      o_ph_r  <= phase_r;
      o_sc_r  <= scnt_r;
      o_pos_r <= door_ok ? rd_pos : '0;
      o_tgt_r <= door_ok ? rd_tgt : '0;
    end
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
      frac_r  <= '0;
      dflt_r  <= '0;
      smap_r  <= '0;
      mov_r   <= '0;
      opn_r   <= '0;
      cls_r   <= '1;
      cal_r   <= '0;
      od_r    <= '0;
      cd_r    <= '0;
      calib_r <= 1'b0;
      phase_r <= PH_IDLE;
      scnt_r  <= '0;
      for (int k = 0; k < NUM_DOORS; k++) begin
        pos_r[k] <= '0;
        tgt_r[k] <= '0;
        otr_r[k] <= '0;
        ctr_r[k] <= '0;
        cs_r[k]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
      mov_r   <= mov_nxt;
      opn_r   <= opn_nxt;
      cls_r   <= cls_nxt;
      cal_r   <= cal_nxt;
      od_r    <= od_nxt;
      cd_r    <= cd_nxt;
      calib_r <= calib_nxt;
      phase_r <= phase_nxt;
      scnt_r  <= scnt_nxt;
      pos_r   <= pos_nxt;
      tgt_r   <= tgt_nxt;
      otr_r   <= otr_nxt;
      ctr_r   <= ctr_nxt;
      cs_r    <= cs_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_OPEN_FRACTION:  frac_r <= cfg_data[9:0];
          CFG_DEFAULT_TRAVEL: dflt_r <= cfg_data;
          CFG_STAGE_MAP:      smap_r <= cfg_data[14:0];
          default: ;
        endcase
      end
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;

  assign out_open_drive         = o_od_r;
  assign out_close_drive        = o_cd_r;
  assign out_open_limits        = o_ol_r;
  assign out_close_limits       = o_cl_r;
  assign out_moving_mask        = o_mv_r;
  assign out_calibrated_mask    = o_cb_r;
  assign out_calibrating        = o_cal_r;
  assign out_cal_phase          = o_ph_r;
  assign out_active_stage_count = o_sc_r;
  assign out_selected_position  = o_pos_r;
  assign out_selected_target    = o_tgt_r;

endmodule
